// ===== rtl/core/advert_payload_field_parser_top_macros.svh =====
// Assertion macros for the advertisement payload field parser.
`ifndef ADVERT_PAYLOAD_FIELD_PARSER_TOP_MACROS_SVH
`define ADVERT_PAYLOAD_FIELD_PARSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge out of reset.
`define APFP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("apfp: same-cycle check failed");
// Next-cycle implication, checked on every clock edge out of reset.
`define APFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apfp: next-cycle check failed");
`else
`define APFP_ASSERT_IMPLY(lbl, ante, cons)
`define APFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/apfp_pkg.sv =====
// Types and constants shared by the advertisement payload field parser.
package apfp_pkg;

    // Payload layout.
    localparam int unsigned POS_W     = 8;
    localparam logic [7:0]  KEY_END   = 8'd32;
    localparam logic [7:0]  TS_LAST   = 8'd35;
    localparam logic [7:0]  TS_END    = 8'd36;
    localparam logic [7:0]  FIXED_LEN = 8'd100;   // 32 + 4 + 64
    localparam logic [7:0]  LOC_START = 8'd101;
    localparam logic [7:0]  LAT_LAST  = 8'd104;
    localparam logic [7:0]  LON_LAST  = 8'd108;
    localparam logic [7:0]  LOC_LEN   = 8'd8;
    localparam logic [7:0]  FEAT_LEN  = 8'd2;

    // Flag byte bits.
    localparam int unsigned FLAG_LOC  = 4;
    localparam int unsigned FLAG_F1   = 5;
    localparam int unsigned FLAG_F2   = 6;
    localparam int unsigned FLAG_NAME = 7;

    // Output queue geometry.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef enum logic [3:0] {
        KIND_KEY   = 4'd0,
        KIND_TS    = 4'd1,
        KIND_SIG   = 4'd2,
        KIND_FLAGS = 4'd3,
        KIND_LAT   = 4'd4,
        KIND_LON   = 4'd5,
        KIND_FEAT1 = 4'd6,
        KIND_FEAT2 = 4'd7,
        KIND_NAME  = 4'd8,
        KIND_END   = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        t_kind       field_kind;
        logic [7:0]  byte_index;
        logic [31:0] field_value;
        t_status     parse_status;
        logic [3:0]  node_type;
        logic        has_location;
        logic        has_feature_one;
        logic        has_feature_two;
        logic        end_of_payload;
    } t_result;

    // Up to two results produced by one item, field result first.
    typedef struct packed {
        logic    a_valid;
        logic    b_valid;
        t_result a;
        t_result b;
    } t_push;

endpackage

// ===== rtl/core/apfp_decode.sv =====
// Input register, parse state and per-byte field decode.
module apfp_decode #(
    parameter int MAX_PAYLOAD_BYTES = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic                 i_room,
    output apfp_pkg::t_push      o_push
);

    localparam logic [apfp_pkg::POS_W-1:0] MAX_POS = apfp_pkg::POS_W'(MAX_PAYLOAD_BYTES);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic [7:0]  r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_flag, n_flag;
    logic        r_term, n_term;

    logic        advance;
    logic [7:0]  loc_end, f1_end, f2_end;
    logic [7:0]  e_loc_end, e_f1_end, e_f2_end;
    apfp_pkg::t_result res_a, res_b;
    logic        a_valid;

    // The held item moves on when the queue has room for two results.
    assign advance    = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Optional field boundaries from the stored flag byte.
    assign loc_end = apfp_pkg::LOC_START + (r_flag[apfp_pkg::FLAG_LOC] ? apfp_pkg::LOC_LEN : 8'd0);
    assign f1_end  = loc_end + (r_flag[apfp_pkg::FLAG_F1] ? apfp_pkg::FEAT_LEN : 8'd0);
    assign f2_end  = f1_end + (r_flag[apfp_pkg::FLAG_F2] ? apfp_pkg::FEAT_LEN : 8'd0);

    // Boundaries from the flag byte as it stands after this item.
    assign e_loc_end = apfp_pkg::LOC_START
                     + (n_flag[apfp_pkg::FLAG_LOC] ? apfp_pkg::LOC_LEN : 8'd0);
    assign e_f1_end  = e_loc_end + (n_flag[apfp_pkg::FLAG_F1] ? apfp_pkg::FEAT_LEN : 8'd0);
    assign e_f2_end  = e_f1_end + (n_flag[apfp_pkg::FLAG_F2] ? apfp_pkg::FEAT_LEN : 8'd0);

    // Field decode for the held byte.
    always_comb begin
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_flag  = r_flag;
        n_term  = r_term;
        a_valid = 1'b0;
        res_a   = '0;
        if (r_pos < MAX_POS) begin
            n_acc = {r_in_byte, r_acc[31:8]};
            n_pos = r_pos + 8'd1;
            priority if (r_pos < apfp_pkg::KEY_END) begin
                a_valid          = 1'b1;
                res_a.field_kind = apfp_pkg::KIND_KEY;
                res_a.byte_index = r_pos;
                res_a.field_value = {24'd0, r_in_byte};
            end else if (r_pos < apfp_pkg::TS_END) begin
                if (r_pos == apfp_pkg::TS_LAST) begin
                    a_valid           = 1'b1;
                    res_a.field_kind  = apfp_pkg::KIND_TS;
                    res_a.field_value = n_acc;
                end
            end else if (r_pos < apfp_pkg::FIXED_LEN) begin
                a_valid           = 1'b1;
                res_a.field_kind  = apfp_pkg::KIND_SIG;
                res_a.byte_index  = r_pos - apfp_pkg::TS_END;
                res_a.field_value = {24'd0, r_in_byte};
            end else if (r_pos == apfp_pkg::FIXED_LEN) begin
                n_flag            = r_in_byte;
                a_valid           = 1'b1;
                res_a.field_kind  = apfp_pkg::KIND_FLAGS;
                res_a.field_value = {24'd0, r_in_byte};
            end else if (r_pos < loc_end) begin
                if (r_pos == apfp_pkg::LAT_LAST) begin
                    a_valid           = 1'b1;
                    res_a.field_kind  = apfp_pkg::KIND_LAT;
                    res_a.field_value = n_acc;
                end else if (r_pos == apfp_pkg::LON_LAST) begin
                    a_valid           = 1'b1;
                    res_a.field_kind  = apfp_pkg::KIND_LON;
                    res_a.field_value = n_acc;
                end
            end else if (r_pos < f1_end) begin
                if (r_pos == f1_end - 8'd1) begin
                    a_valid           = 1'b1;
                    res_a.field_kind  = apfp_pkg::KIND_FEAT1;
                    res_a.field_value = {16'd0, n_acc[31:16]};
                end
            end else if (r_pos < f2_end) begin
                if (r_pos == f2_end - 8'd1) begin
                    a_valid           = 1'b1;
                    res_a.field_kind  = apfp_pkg::KIND_FEAT2;
                    res_a.field_value = {16'd0, n_acc[31:16]};
                end
            end else begin
                if (r_flag[apfp_pkg::FLAG_NAME] && !r_term) begin
                    if (r_in_byte == 8'd0) begin
                        n_term = 1'b1;
                    end else begin
                        a_valid           = 1'b1;
                        res_a.field_kind  = apfp_pkg::KIND_NAME;
                        res_a.byte_index  = r_pos - f2_end;
                        res_a.field_value = {24'd0, r_in_byte};
                    end
                end
            end
        end

        // End result on the last byte; truncation is checked in field order.
        res_b                = '0;
        res_b.field_kind     = apfp_pkg::KIND_END;
        res_b.end_of_payload = 1'b1;
        if (n_pos < apfp_pkg::FIXED_LEN) begin
            res_b.parse_status = apfp_pkg::STATUS_SHORT;
        end else if (n_pos > apfp_pkg::FIXED_LEN) begin
            res_b.node_type = n_flag[3:0];
            if (n_flag[apfp_pkg::FLAG_LOC]) begin
                if (n_pos >= e_loc_end) res_b.has_location = 1'b1;
                else res_b.parse_status = apfp_pkg::STATUS_TRUNCATED;
            end
            if (res_b.parse_status == apfp_pkg::STATUS_OK && n_flag[apfp_pkg::FLAG_F1]) begin
                if (n_pos >= e_f1_end) res_b.has_feature_one = 1'b1;
                else res_b.parse_status = apfp_pkg::STATUS_TRUNCATED;
            end
            if (res_b.parse_status == apfp_pkg::STATUS_OK && n_flag[apfp_pkg::FLAG_F2]) begin
                if (n_pos >= e_f2_end) res_b.has_feature_two = 1'b1;
                else res_b.parse_status = apfp_pkg::STATUS_TRUNCATED;
            end
        end
    end

    // Parse state; cleared again after the last byte of a payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_acc  <= '0;
            r_flag <= '0;
            r_term <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_pos  <= '0;
                r_acc  <= '0;
                r_flag <= '0;
                r_term <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_acc  <= n_acc;
                r_flag <= n_flag;
                r_term <= n_term;
            end
        end
    end

    // Results handed to the output queue.
    always_comb begin
        o_push.a_valid = advance && a_valid;
        o_push.b_valid = advance && r_in_last;
        o_push.a       = res_a;
        o_push.b       = res_b;
    end

endmodule

// ===== rtl/core/apfp_outq.sv =====
// Small result queue that takes up to two results a cycle and gives one.
module apfp_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  apfp_pkg::t_push      i_push,
    output logic                 o_room,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output apfp_pkg::t_result    o_result
);

    apfp_pkg::t_result               r_q [apfp_pkg::QUEUE_DEPTH];
    logic [apfp_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [apfp_pkg::QCNT_W-1:0]     r_cnt;
    logic                            pop;
    logic [apfp_pkg::QPTR_W-1:0]     wr_b;
    logic [apfp_pkg::QCNT_W-1:0]     push_n;

    assign o_room      = r_cnt <= apfp_pkg::QCNT_W'(apfp_pkg::QUEUE_DEPTH - 2);
    assign o_out_valid = r_cnt != '0;
    assign o_result    = r_q[r_rd];
    assign pop         = o_out_valid && i_out_ready;
    assign wr_b        = r_wr + apfp_pkg::QPTR_W'(i_push.a_valid);
    assign push_n      = apfp_pkg::QCNT_W'(i_push.a_valid) + apfp_pkg::QCNT_W'(i_push.b_valid);

    // Result storage; the field result goes in ahead of the end result.
    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) r_q[r_wr] <= i_push.a;
        if (i_push.b_valid) r_q[wr_b] <= i_push.b;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + push_n[apfp_pkg::QPTR_W-1:0];
            if (pop) r_rd <= r_rd + apfp_pkg::QPTR_W'(1);
            r_cnt <= r_cnt + push_n - apfp_pkg::QCNT_W'(pop);
        end
    end

endmodule

// ===== rtl/core/advert_payload_field_parser_top.sv =====
// Top level of the advertisement payload field parser.
//
// Input channel (i_in_valid / o_in_ready) takes one payload byte per item with
// i_last_byte marking the final byte. Output channel (o_out_valid / i_out_ready)
// gives one result per item: key and signature bytes, the timestamp, the flag
// byte, the selected optional words, name bytes and, on the last byte, an end
// result carrying the parse status and presence bits.
// A byte is held in the input register, decoded, and its results are written
// to a four-entry output queue, from which its first result is offered.
// The block takes one byte per cycle while the queue has room for two results.
// A last byte that also completes a field gives two results, which leave the
// queue one after the other, field result first.
// The input register moves on only while the queue has room for two results, so
// a stalled receiver backs up into o_in_ready and nothing is dropped. Reset
// empties the queue and the input register and clears the byte position, word
// accumulator, flag byte and name state; no clearing pass.
module advert_payload_field_parser_top #(
    parameter int MAX_PAYLOAD_BYTES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_field_kind,
    output logic [7:0]  o_byte_index,
    output logic [31:0] o_field_value,
    output logic [1:0]  o_parse_status,
    output logic [3:0]  o_node_type,
    output logic        o_has_location,
    output logic        o_has_feature_one,
    output logic        o_has_feature_two,
    output logic        o_end_of_payload
);

`include "advert_payload_field_parser_top_macros.svh"

    apfp_pkg::t_push   push;
    apfp_pkg::t_result result;
    logic              room;

    // Byte decode and parse state.
    apfp_decode #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_room      (room),
        .o_push      (push)
    );

    // Output queue.
    apfp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    // Result fields onto the ports.
    assign o_field_kind      = result.field_kind;
    assign o_byte_index      = result.byte_index;
    assign o_field_value     = result.field_value;
    assign o_parse_status    = result.parse_status;
    assign o_node_type       = result.node_type;
    assign o_has_location    = result.has_location;
    assign o_has_feature_one = result.has_feature_one;
    assign o_has_feature_two = result.has_feature_two;
    assign o_end_of_payload  = result.end_of_payload;

    // The end mark and the end kind always travel together.
    `APFP_ASSERT_IMPLY(a_end_kind, o_out_valid && o_end_of_payload, o_field_kind == apfp_pkg::KIND_END)
    // Only an end result carries a status.
    `APFP_ASSERT_IMPLY(a_status_on_end, o_out_valid && !o_end_of_payload, o_parse_status == apfp_pkg::STATUS_OK)
    // A short payload reports no optional field.
    `APFP_ASSERT_IMPLY(a_short_no_fields, o_out_valid && o_parse_status == apfp_pkg::STATUS_SHORT, !o_has_location && !o_has_feature_one && !o_has_feature_two)
    // Both results of a last byte are queued: the end result follows without a gap in data.
    `APFP_ASSERT_NEXT(a_end_follows, o_out_valid && i_out_ready && !o_end_of_payload && push.b_valid, o_out_valid)

endmodule

// ===== test/tb_advert_payload_field_parser_top.sv =====
// Self-checking testbench for the advertisement payload field parser top level.
module tb_advert_payload_field_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES        = 255;
    localparam int WAIT_MAX         = 8;
    localparam int RANDOM_ITEMS     = 1050;
    localparam int DRAIN_CYCLES     = 20;
    localparam int MISMATCH_REPORTS = 10;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_field_kind;
    logic [7:0]  o_byte_index;
    logic [31:0] o_field_value;
    logic [1:0]  o_parse_status;
    logic [3:0]  o_node_type;
    logic        o_has_location;
    logic        o_has_feature_one;
    logic        o_has_feature_two;
    logic        o_end_of_payload;

    t_byte_item          payload_bytes[$];
    apfp_pkg::t_result   expected_fields[$];
    apfp_pkg::t_result   seen_field;

    // Parser state as the predictor tracks it.
    logic [7:0]  parse_pos = 8'd0;
    logic [31:0] word_shift = 32'd0;
    logic [7:0]  flag_byte = 8'd0;
    logic        name_done = 1'b0;

    int          total_bytes = 0;
    int          accepted_bytes = 0;
    int          mismatches = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    bit          in_steady = 1'b0;
    bit          out_steady = 1'b0;

    advert_payload_field_parser_top #(
        .MAX_PAYLOAD_BYTES(MAX_BYTES)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_field_kind      (o_field_kind),
        .o_byte_index      (o_byte_index),
        .o_field_value     (o_field_value),
        .o_parse_status    (o_parse_status),
        .o_node_type       (o_node_type),
        .o_has_location    (o_has_location),
        .o_has_feature_one (o_has_feature_one),
        .o_has_feature_two (o_has_feature_two),
        .o_end_of_payload  (o_end_of_payload)
    );

    assign seen_field = {o_field_kind, o_byte_index, o_field_value, o_parse_status,
                         o_node_type, o_has_location, o_has_feature_one,
                         o_has_feature_two, o_end_of_payload};

    // Optional field boundaries that follow from a flag byte.
    function automatic void optional_ends(input logic [7:0] flags,
                                          output int unsigned loc_end,
                                          output int unsigned f1_end,
                                          output int unsigned f2_end);
        loc_end = int'(apfp_pkg::LOC_START)
                + (flags[apfp_pkg::FLAG_LOC] ? int'(apfp_pkg::LOC_LEN) : 0);
        f1_end  = loc_end + (flags[apfp_pkg::FLAG_F1] ? int'(apfp_pkg::FEAT_LEN) : 0);
        f2_end  = f1_end + (flags[apfp_pkg::FLAG_F2] ? int'(apfp_pkg::FEAT_LEN) : 0);
    endfunction

    function automatic apfp_pkg::t_result field_result(input apfp_pkg::t_kind kind,
                                                       input int unsigned idx,
                                                       input logic [31:0] value);
        apfp_pkg::t_result r;
        r = '0;
        r.field_kind  = kind;
        r.byte_index  = idx[7:0];
        r.field_value = value;
        return r;
    endfunction

    function automatic string field_text(input apfp_pkg::t_result r);
        return $sformatf("kind %0d idx %0d value %h status %0d type %0d loc %b f1 %b f2 %b end %b",
                         r.field_kind, r.byte_index, r.field_value, r.parse_status,
                         r.node_type, r.has_location, r.has_feature_one,
                         r.has_feature_two, r.end_of_payload);
    endfunction

    // Wait drawn per item; steady stretches with no idling come and go at random.
    function automatic int draw_wait(inout bit steady);
        if ($urandom_range(0, 39) == 0) begin
            steady = !steady;
        end
        return steady ? 0 : int'($urandom_range(0, WAIT_MAX));
    endfunction

    // Predicts the results of one accepted payload byte.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        int unsigned       p;
        int unsigned       loc_end;
        int unsigned       f1_end;
        int unsigned       f2_end;
        apfp_pkg::t_result done;
        p = parse_pos;
        optional_ends(flag_byte, loc_end, f1_end, f2_end);
        if (p < MAX_BYTES) begin
            word_shift = {b, word_shift[31:8]};
            if (p < apfp_pkg::KEY_END) begin
                expected_fields.push_back(field_result(apfp_pkg::KIND_KEY, p, {24'd0, b}));
            end else if (p < apfp_pkg::TS_END) begin
                if (p == apfp_pkg::TS_LAST) begin
                    expected_fields.push_back(field_result(apfp_pkg::KIND_TS, 0, word_shift));
                end
            end else if (p < apfp_pkg::FIXED_LEN) begin
                expected_fields.push_back(field_result(apfp_pkg::KIND_SIG,
                                                       p - apfp_pkg::TS_END, {24'd0, b}));
            end else if (p == apfp_pkg::FIXED_LEN) begin
                flag_byte = b;
                expected_fields.push_back(field_result(apfp_pkg::KIND_FLAGS, 0, {24'd0, b}));
            end else if (p < loc_end) begin
                if (p == apfp_pkg::LAT_LAST) begin
                    expected_fields.push_back(field_result(apfp_pkg::KIND_LAT, 0, word_shift));
                end else if (p == apfp_pkg::LON_LAST) begin
                    expected_fields.push_back(field_result(apfp_pkg::KIND_LON, 0, word_shift));
                end
            end else if (p < f1_end) begin
                if (p == f1_end - 1) begin
                    expected_fields.push_back(field_result(apfp_pkg::KIND_FEAT1, 0,
                                                           word_shift >> 16));
                end
            end else if (p < f2_end) begin
                if (p == f2_end - 1) begin
                    expected_fields.push_back(field_result(apfp_pkg::KIND_FEAT2, 0,
                                                           word_shift >> 16));
                end
            end else if (flag_byte[apfp_pkg::FLAG_NAME] && !name_done) begin
                // A zero byte ends the name and is not emitted itself.
                if (b == 8'd0) begin
                    name_done = 1'b1;
                end else begin
                    expected_fields.push_back(field_result(apfp_pkg::KIND_NAME, p - f2_end,
                                                           {24'd0, b}));
                end
            end
            parse_pos = 8'(p + 1);
        end
        if (last) begin
            done = field_result(apfp_pkg::KIND_END, 0, 32'd0);
            done.end_of_payload = 1'b1;
            if (parse_pos < apfp_pkg::FIXED_LEN) begin
                done.parse_status = apfp_pkg::STATUS_SHORT;
            end else if (parse_pos > apfp_pkg::FIXED_LEN) begin
                // The flag byte may have arrived with this very byte.
                optional_ends(flag_byte, loc_end, f1_end, f2_end);
                done.node_type = flag_byte[3:0];
                if (flag_byte[apfp_pkg::FLAG_LOC]) begin
                    if (parse_pos >= loc_end) done.has_location = 1'b1;
                    else done.parse_status = apfp_pkg::STATUS_TRUNCATED;
                end
                if (done.parse_status == apfp_pkg::STATUS_OK && flag_byte[apfp_pkg::FLAG_F1]) begin
                    if (parse_pos >= f1_end) done.has_feature_one = 1'b1;
                    else done.parse_status = apfp_pkg::STATUS_TRUNCATED;
                end
                if (done.parse_status == apfp_pkg::STATUS_OK && flag_byte[apfp_pkg::FLAG_F2]) begin
                    if (parse_pos >= f2_end) done.has_feature_two = 1'b1;
                    else done.parse_status = apfp_pkg::STATUS_TRUNCATED;
                end
            end
            expected_fields.push_back(done);
            parse_pos  = 8'd0;
            word_shift = 32'd0;
            flag_byte  = 8'd0;
            name_done  = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        t_byte_item it;
        it.data = data;
        it.last = last;
        payload_bytes.push_back(it);
    endtask

    // Queues one payload of the given length with the given flag byte; name bytes
    // before the terminator position are nonzero, the terminator is zero, the rest random.
    task automatic add_payload(input int len, input logic [7:0] flags, input int name_zero);
        int unsigned loc_end;
        int unsigned f1_end;
        int unsigned f2_end;
        int          idx;
        logic [7:0]  data;
        optional_ends(flags, loc_end, f1_end, f2_end);
        for (int p = 0; p < len; p++) begin
            data = 8'($urandom_range(0, 255));
            if (p == apfp_pkg::FIXED_LEN) begin
                data = flags;
            end else if (p >= f2_end) begin
                idx = p - f2_end;
                if (idx == name_zero) data = 8'd0;
                else if (idx < name_zero) data = 8'($urandom_range(1, 255));
            end
            push_byte(data, p == len - 1);
        end
    endtask

    // Mostly well-formed payloads, some cut off after the fixed part, a few short.
    task automatic add_random_payload();
        logic [7:0]  flags;
        int unsigned loc_end;
        int unsigned f1_end;
        int unsigned f2_end;
        int          name_len;
        int          full_len;
        int          len;
        flags = 8'($urandom_range(0, 255));
        optional_ends(flags, loc_end, f1_end, f2_end);
        name_len = flags[apfp_pkg::FLAG_NAME] ? $urandom_range(0, 16) : 0;
        full_len = f2_end + name_len + $urandom_range(0, 3);
        case ($urandom_range(0, 7))
            0: begin
                len = $urandom_range(1, apfp_pkg::FIXED_LEN - 1);
            end
            1, 2: begin
                len = $urandom_range(apfp_pkg::FIXED_LEN, full_len);
            end
            default: begin
                len = full_len;
            end
        endcase
        add_payload(len, flags, $urandom_range(0, name_len));
    endtask

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reset, stimulus and end of run.
    initial begin
        int random_start;
        // Single-byte and two-byte payloads with extreme byte values.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);
        random_start = payload_bytes.size();
        // Overlong payload whose unterminated name runs into the position limit.
        add_payload(MAX_BYTES + 3, 8'hF0 | 8'($urandom_range(0, 15)), MAX_BYTES);
        // Exactly the fixed part, with no flag byte.
        add_payload(apfp_pkg::FIXED_LEN, 8'h00, 0);
        // Flag byte as the last byte, with every option selected and none present.
        add_payload(apfp_pkg::FIXED_LEN + 1, 8'hFF, 0);
        // Latitude completed by the last byte; the longitude is cut off.
        add_payload(apfp_pkg::LAT_LAST + 1, 8'h10 | 8'($urandom_range(0, 15)), 0);
        while (payload_bytes.size() < random_start + RANDOM_ITEMS) begin
            add_random_payload();
        end
        total_bytes = payload_bytes.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_bytes == total_bytes);
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_fields.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // Byte driver: presents queued items with random gaps and predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                parse_byte(i_data_byte, i_last_byte);
                accepted_bytes++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (payload_bytes.size() != 0) begin
                    i_in_valid  <= 1'b1;
                    i_data_byte <= payload_bytes[0].data;
                    i_last_byte <= payload_bytes[0].last;
                    void'(payload_bytes.pop_front());
                    in_gap = draw_wait(in_steady);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random backpressure and field-by-field comparison.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_fields.size() == 0) begin
                    if (mismatches < MISMATCH_REPORTS) begin
                        $display("unexpected result: %s", field_text(seen_field));
                    end
                    mismatches++;
                end else begin
                    if (seen_field.field_kind      !== expected_fields[0].field_kind      ||
                        seen_field.byte_index      !== expected_fields[0].byte_index      ||
                        seen_field.field_value     !== expected_fields[0].field_value     ||
                        seen_field.parse_status    !== expected_fields[0].parse_status    ||
                        seen_field.node_type       !== expected_fields[0].node_type       ||
                        seen_field.has_location    !== expected_fields[0].has_location    ||
                        seen_field.has_feature_one !== expected_fields[0].has_feature_one ||
                        seen_field.has_feature_two !== expected_fields[0].has_feature_two ||
                        seen_field.end_of_payload  !== expected_fields[0].end_of_payload) begin
                        if (mismatches < MISMATCH_REPORTS) begin
                            $display("mismatch: expected %s", field_text(expected_fields[0]));
                            $display("          actual   %s", field_text(seen_field));
                        end
                        mismatches++;
                    end
                    void'(expected_fields.pop_front());
                end
                out_gap = draw_wait(out_steady);
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/apfp_pkg.sv
rtl/core/apfp_decode.sv
rtl/core/apfp_outq.sv
rtl/core/advert_payload_field_parser_top.sv
test/tb_advert_payload_field_parser_top.sv
